### rtl/core/sip_pkg.sv
// Shared widths, types and status codes for the segment intersection pipeline.
// No dependencies; imported by sip_divider and segment_intersection_point.
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

    localparam int CoordBits = 16;                   // significant bits of a coordinate
    localparam int FracBits  = 8;                    // fraction bits of the result
    localparam int InW       = 16;                   // field width on the input bus
    localparam int OutW      = 24;                   // result field width
    localparam int DiffW     = CoordBits + 1;        // direction and offset vectors
    localparam int ProdW     = 2 * DiffW;            // one cross-product term
    localparam int DenW      = ProdW + 1;            // denominator and numerators
    localparam int NumW      = DenW + CoordBits + 2; // c*den + t*delta
    localparam int ShW       = NumW + FracBits;      // numerator scaled by 2^FracBits
    localparam int QuoW      = CoordBits + FracBits; // quotient magnitude bits
    localparam int InDataW   = 8 * InW;
    localparam int OutDataW  = 2 * OutW;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_PARALLEL = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        logic    neg_x;
        logic    neg_y;
    } side_t;

endpackage

`default_nettype wire

### rtl/core/segment_intersection_point.sv
// Top level: segment pair intersection test and fixed-point crossing point.
// Depends on sip_pkg and sip_divider.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                              tuser
// s_axis    in   8 x 16-bit endpoint coordinates    -
// m_axis    out  cross_x, cross_y (24 bits each)    status
//
// One transfer can enter every cycle while the output is not stalled. The
// depth is set by the divider, one quotient bit per stage. Reset clears only
// the valid bits. When the output holds a transfer that is not taken, the
// whole pipeline stalls in place.

module segment_intersection_point
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  wire logic [sip_pkg::InDataW-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [sip_pkg::OutDataW-1:0]    m_tdata,  // cross_x, cross_y
    output logic      [1:0]                      m_tuser   // status
);
    import sip_pkg::*;

    localparam int NumStages = 6 + QuoW;
    localparam int DivFirst  = 5;

    logic adv;
    logic valid_reg [NumStages];

    assign adv      = !valid_reg[NumStages-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NumStages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NumStages; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NumStages; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    // stage 1: unpack, direction and offset vectors
    logic signed [CoordBits-1:0] ax, ay, bx, by, cx, cy, ex, ey;
    logic signed [DiffW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, wx_reg, wy_reg;
    logic signed [CoordBits-1:0] ax1_reg, ay1_reg;

    always_comb
    begin
        ax = signed'(s_tdata[0*InW +: CoordBits]);
        ay = signed'(s_tdata[1*InW +: CoordBits]);
        bx = signed'(s_tdata[2*InW +: CoordBits]);
        by = signed'(s_tdata[3*InW +: CoordBits]);
        cx = signed'(s_tdata[4*InW +: CoordBits]);
        cy = signed'(s_tdata[5*InW +: CoordBits]);
        ex = signed'(s_tdata[6*InW +: CoordBits]);
        ey = signed'(s_tdata[7*InW +: CoordBits]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1x_reg <= DiffW'(bx) - DiffW'(ax);
            d1y_reg <= DiffW'(by) - DiffW'(ay);
            d2x_reg <= DiffW'(ex) - DiffW'(cx);
            d2y_reg <= DiffW'(ey) - DiffW'(cy);
            wx_reg  <= DiffW'(ax) - DiffW'(cx);
            wy_reg  <= DiffW'(ay) - DiffW'(cy);
            ax1_reg <= ax;
            ay1_reg <= ay;
        end
    end

    // stage 2: cross-product terms
    logic signed [ProdW-1:0] pda_reg, pdb_reg, psa_reg, psb_reg, pta_reg, ptb_reg;
    logic signed [DiffW-1:0] d1x2_reg, d1y2_reg;
    logic signed [CoordBits-1:0] ax2_reg, ay2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pda_reg  <= d1x_reg * d2y_reg;
            pdb_reg  <= d2x_reg * d1y_reg;
            psa_reg  <= d1x_reg * wy_reg;
            psb_reg  <= d1y_reg * wx_reg;
            pta_reg  <= d2x_reg * wy_reg;
            ptb_reg  <= d2y_reg * wx_reg;
            d1x2_reg <= d1x_reg;
            d1y2_reg <= d1y_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    // stage 3: denominator and numerators
    logic signed [DenW-1:0] den3_reg, snum_reg, tnum_reg;
    logic signed [DiffW-1:0] d1x3_reg, d1y3_reg;
    logic signed [CoordBits-1:0] ax3_reg, ay3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den3_reg <= DenW'(pda_reg) - DenW'(pdb_reg);
            snum_reg <= DenW'(psa_reg) - DenW'(psb_reg);
            tnum_reg <= DenW'(pta_reg) - DenW'(ptb_reg);
            d1x3_reg <= d1x2_reg;
            d1y3_reg <= d1y2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
    end

    // stage 4: classify, form c*den and t*delta
    status_t status3;
    logic    s_ok, t_ok;

    always_comb
    begin
        if (den3_reg > 0)
        begin
            s_ok = snum_reg >= 0 && snum_reg <= den3_reg;
            t_ok = tnum_reg >= 0 && tnum_reg <= den3_reg;
        end
        else
        begin
            s_ok = snum_reg <= 0 && snum_reg >= den3_reg;
            t_ok = tnum_reg <= 0 && tnum_reg >= den3_reg;
        end
        if (den3_reg == 0)
            status3 = ST_PARALLEL;
        else if (s_ok && t_ok)
            status3 = ST_HIT;
        else
            status3 = ST_MISS;
    end

    logic signed [DenW+CoordBits-1:0] mcx_reg, mcy_reg;
    logic signed [DenW+DiffW-1:0]     mtx_reg, mty_reg;
    logic signed [DenW-1:0]           den4_reg;
    status_t                          status4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mcx_reg     <= ax3_reg * den3_reg;
            mcy_reg     <= ay3_reg * den3_reg;
            mtx_reg     <= tnum_reg * d1x3_reg;
            mty_reg     <= tnum_reg * d1y3_reg;
            den4_reg    <= den3_reg;
            status4_reg <= status3;
        end
    end

    // stage 5: full numerator, signs and magnitudes, divider operands
    logic signed [NumW-1:0] nx, ny;
    logic [NumW-1:0]        magx, magy;
    logic [ShW-1:0]         shx, shy;
    logic [DenW-1:0]        dmag;

    always_comb
    begin
        nx   = NumW'(mcx_reg) + NumW'(mtx_reg);
        ny   = NumW'(mcy_reg) + NumW'(mty_reg);
        magx = nx[NumW-1] ? NumW'(-nx) : NumW'(nx);
        magy = ny[NumW-1] ? NumW'(-ny) : NumW'(ny);
        shx  = ShW'(magx) << FracBits;
        shy  = ShW'(magy) << FracBits;
        dmag = den4_reg[DenW-1] ? DenW'(-den4_reg) : DenW'(den4_reg);
    end

    logic [DenW-1:0] remx_reg, remy_reg, div_reg;
    logic [QuoW-1:0] lowx_reg, lowy_reg;
    side_t           side_reg [QuoW+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // for a hit the quotient is below 2^QuoW, so the high part is already below the divisor
            remx_reg          <= shx[QuoW +: DenW];
            remy_reg          <= shy[QuoW +: DenW];
            lowx_reg          <= shx[QuoW-1:0];
            lowy_reg          <= shy[QuoW-1:0];
            div_reg           <= dmag;
            side_reg[0].status <= status4_reg;
            side_reg[0].neg_x <= nx[NumW-1] ^ den4_reg[DenW-1];
            side_reg[0].neg_y <= ny[NumW-1] ^ den4_reg[DenW-1];
            for (int k = 1; k <= QuoW; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    logic [QuoW-1:0] qx, qy;

    sip_divider u_div_x
    (
        .clk    (clk),
        .en     (adv),
        .rem_in (remx_reg),
        .low_in (lowx_reg),
        .div_in (div_reg),
        .quo    (qx)
    );

    sip_divider u_div_y
    (
        .clk    (clk),
        .en     (adv),
        .rem_in (remy_reg),
        .low_in (lowy_reg),
        .div_in (div_reg),
        .quo    (qy)
    );

    // output stage: apply sign, zero unless hit
    logic signed [QuoW:0] sx, sy;
    logic [OutW-1:0]      cross_x_next, cross_y_next;
    logic [OutW-1:0]      cross_x_reg, cross_y_reg;
    status_t              status_reg;

    always_comb
    begin
        sx = side_reg[QuoW].neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        sy = side_reg[QuoW].neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        if (side_reg[QuoW].status == ST_HIT)
        begin
            cross_x_next = OutW'(sx);
            cross_y_next = OutW'(sy);
        end
        else
        begin
            cross_x_next = '0;
            cross_y_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cross_x_reg <= cross_x_next;
            cross_y_reg <= cross_y_next;
            status_reg  <= side_reg[QuoW].status;
        end
    end

    assign m_tdata = {cross_y_reg, cross_x_reg};
    assign m_tuser = status_reg;

    a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_HIT |-> m_tdata == '0)
        else $error("nonzero point on a non-hit result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == ST_HIT || m_tuser == ST_MISS || m_tuser == ST_PARALLEL)
        else $error("undefined status code");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> valid_reg[DivFirst] == $past(valid_reg[DivFirst]))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

### rtl/core/sip_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on sip_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module sip_divider
(
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [sip_pkg::DenW-1:0]    rem_in,  // high part of dividend, below divisor
    input  wire logic [sip_pkg::QuoW-1:0]    low_in,  // low part of dividend
    input  wire logic [sip_pkg::DenW-1:0]    div_in,
    output logic      [sip_pkg::QuoW-1:0]    quo
);
    import sip_pkg::*;

    logic [DenW-1:0] rem_reg [QuoW+1];
    logic [QuoW-1:0] low_reg [QuoW+1];
    logic [DenW-1:0] div_reg [QuoW+1];

    always_comb
    begin
        rem_reg[0] = rem_in;
        low_reg[0] = low_in;
        div_reg[0] = div_in;
    end

    for (genvar i = 0; i < QuoW; i++)
    begin : g_step
        logic [DenW:0]   trial;
        logic            take;
        logic [DenW-1:0] rem_next;
        logic [QuoW-1:0] low_next;

        // low word shifts out dividend bits on top and quotient bits in at the bottom
        always_comb
        begin
            trial    = {rem_reg[i], low_reg[i][QuoW-1]};
            take     = trial >= {1'b0, div_reg[i]};
            rem_next = take ? DenW'(trial - {1'b0, div_reg[i]}) : trial[DenW-1:0];
            low_next = {low_reg[i][QuoW-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= rem_next;
                low_reg[i+1] <= low_next;
                div_reg[i+1] <= div_reg[i];
            end
        end
    end

    assign quo = low_reg[QuoW];

endmodule

`default_nettype wire
